>>> rtl/core/fqsd_pkg.sv
// Shared types and constants for the FIFO queue with find and delete.
// Used by fqsd_ctrl, fqsd_dp and fifo_queue_with_search_delete; depends on nothing.
package fqsd_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int DATA_W    = 32;
    localparam int ACT_W     = 3;
    localparam int STAT_W    = 2;
    localparam int POS_W     = 4;
    localparam int LEN_W     = 5;

    typedef enum logic [ACT_W-1:0] {
        ACT_ENQUEUE = 3'd0,
        ACT_DEQUEUE = 3'd1,
        ACT_FIND    = 3'd2,
        ACT_DELETE  = 3'd3,
        ACT_CLEAR   = 3'd4
    } action_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_DONE     = 2'd0,
        STAT_FULL     = 2'd1,
        STAT_EMPTY    = 2'd2,
        STAT_NOTFOUND = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_FIND,
        S_SHIFT,
        S_RESP
    } ctrl_state_t;

    // Which logical entry the memory read port fetches.
    typedef enum logic [1:0] {
        RD_FIRST,
        RD_NEXT,
        RD_SKIP
    } rd_sel_t;

    // Source of the reported position.
    typedef enum logic [1:0] {
        POS_ZERO,
        POS_COUNT,
        POS_IDX
    } pos_sel_t;

    typedef struct packed {
        logic     latch;
        logic     rd_en;
        rd_sel_t  rd_sel;
        logic     idx_clr;
        logic     idx_inc;
        logic     enq;
        logic     deq;
        logic     shift_wr;
        logic     drop;
        logic     clear;
        logic     res_set;
        status_t  res_status;
        pos_sel_t res_pos;
        logic     out_load;
    } dp_cmd_t;

    typedef struct packed {
        action_t action;
        logic    empty;
        logic    full;
        logic    match;
        logic    last;
        logic    out_free;
    } dp_sts_t;

endpackage

>>> rtl/core/fqsd_dp.sv
// Datapath: circular entry memory, head and fill count, scan index and result register.
// Depends on fqsd_pkg; driven by fqsd_ctrl through dp_cmd_t.
module fqsd_dp
    import fqsd_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [ACT_W-1:0]         action,
    input  logic signed [DATA_W-1:0] value,
    input  logic                     out_stall,
    output logic                     out_valid,
    output logic [STAT_W-1:0]        status,
    output logic [POS_W-1:0]         position,
    output logic [LEN_W-1:0]         length,
    input  dp_cmd_t                  cmd,
    output dp_sts_t                  sts
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;

    logic signed [DATA_W-1:0] mem [DEPTH];

    logic [ACT_W-1:0]         action_reg;
    logic signed [DATA_W-1:0] value_reg;
    logic signed [DATA_W-1:0] rdata_reg;
    logic [AW-1:0]            head_reg, head_next;
    logic [CW-1:0]            count_reg, count_next;
    logic [CW-1:0]            idx_reg, idx_next;
    status_t                  res_st_reg;
    logic [CW-1:0]            res_pos_reg;
    logic                     out_valid_reg, out_valid_next;
    logic [STAT_W-1:0]        status_reg;
    logic [POS_W-1:0]         position_reg;
    logic [LEN_W-1:0]         length_reg;

    logic [CW-1:0]            rd_logical;
    logic [AW-1:0]            rd_addr;
    logic                     wr_en;
    logic [AW-1:0]            wr_addr;
    logic signed [DATA_W-1:0] wr_data;
    logic [CW-1:0]            pos_value;
    logic [CW+POS_W-1:0]      pos_wide;
    logic [CW+LEN_W-1:0]      len_wide;

    // Logical index counted from the head, mapped onto a slot. The sum stays
    // below twice the depth, so one conditional subtract wraps it.
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                           input logic [CW-1:0] logical);
        logic [SW-1:0] sum;
        sum = SW'(head) + SW'(logical);
        if (sum >= SW'(DEPTH))
        begin
            sum = sum - SW'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    always_comb
    begin
        unique case (cmd.rd_sel)
            RD_FIRST: rd_logical = '0;
            RD_NEXT:  rd_logical = idx_reg + CW'(1);
            RD_SKIP:  rd_logical = idx_reg + CW'(2);
            default:  rd_logical = '0;
        endcase
        rd_addr = phys(head_reg, rd_logical);

        wr_en   = cmd.enq | cmd.shift_wr;
        wr_addr = cmd.enq ? phys(head_reg, count_reg) : phys(head_reg, idx_reg);
        wr_data = cmd.enq ? value_reg : rdata_reg;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        count_next = count_reg;
        head_next  = head_reg;
        idx_next   = idx_reg;
        if (cmd.clear)
        begin
            count_next = '0;
            head_next  = '0;
        end
        else if (cmd.enq)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.deq || cmd.drop)
        begin
            count_next = count_reg - CW'(1);
        end
        if (cmd.deq)
        begin
            head_next = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + AW'(1);
        end
        if (cmd.idx_clr)
        begin
            idx_next = '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_reg + CW'(1);
        end
    end

    always_comb
    begin
        unique case (cmd.res_pos)
            POS_ZERO:  pos_value = '0;
            POS_COUNT: pos_value = count_reg;
            POS_IDX:   pos_value = idx_reg;
            default:   pos_value = '0;
        endcase
        pos_wide = {{POS_W{1'b0}}, res_pos_reg};
        len_wide = {{LEN_W{1'b0}}, count_reg};
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            action_reg <= action;
            value_reg  <= value;
        end
        if (cmd.res_set)
        begin
            res_st_reg  <= cmd.res_status;
            res_pos_reg <= pos_value;
        end
        if (cmd.out_load)
        begin
            status_reg   <= res_st_reg;
            position_reg <= pos_wide[POS_W-1:0];
            length_reg   <= len_wide[LEN_W-1:0];
        end
    end

    assign sts.action   = action_t'(action_reg);
    assign sts.empty    = (count_reg == '0);
    assign sts.full     = (count_reg == CW'(DEPTH));
    assign sts.match    = (rdata_reg == value_reg);
    assign sts.last     = ((idx_reg + CW'(1)) == count_reg);
    assign sts.out_free = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign position  = position_reg;
    assign length    = length_reg;

endmodule

>>> rtl/core/fqsd_ctrl.sv
// Controller: sequences one command at a time through decode, scan, shift and response.
// Depends on fqsd_pkg; drives fqsd_dp through dp_cmd_t and reads dp_sts_t.
module fqsd_ctrl
    import fqsd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    output dp_cmd_t cmd,
    input  dp_sts_t sts
);

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = (state_reg != S_IDLE);

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                cmd.res_set    = 1'b1;
                cmd.res_status = STAT_DONE;
                cmd.res_pos    = POS_ZERO;
                state_next     = S_RESP;
                unique case (sts.action)
                    ACT_ENQUEUE:
                    begin
                        if (sts.full)
                        begin
                            cmd.res_status = STAT_FULL;
                        end
                        else
                        begin
                            cmd.enq     = 1'b1;
                            cmd.res_pos = POS_COUNT;
                        end
                    end
                    ACT_DEQUEUE:
                    begin
                        if (sts.empty)
                        begin
                            cmd.res_status = STAT_EMPTY;
                        end
                        else
                        begin
                            cmd.deq = 1'b1;
                        end
                    end
                    ACT_FIND, ACT_DELETE:
                    begin
                        if (sts.empty)
                        begin
                            cmd.res_status = STAT_NOTFOUND;
                        end
                        else
                        begin
                            cmd.res_set = 1'b0;
                            cmd.rd_en   = 1'b1;
                            cmd.rd_sel  = RD_FIRST;
                            cmd.idx_clr = 1'b1;
                            state_next  = S_FIND;
                        end
                    end
                    ACT_CLEAR:
                    begin
                        cmd.clear = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end

            // The read data holds the entry at the scan index.
            S_FIND:
            begin
                if (sts.match)
                begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = STAT_DONE;
                    cmd.res_pos    = POS_IDX;
                    if (sts.action == ACT_DELETE)
                    begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = RD_NEXT;
                        state_next = S_SHIFT;
                    end
                    else
                    begin
                        state_next = S_RESP;
                    end
                end
                else if (sts.last)
                begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = STAT_NOTFOUND;
                    cmd.res_pos    = POS_ZERO;
                    state_next     = S_RESP;
                end
                else
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_sel  = RD_NEXT;
                    cmd.idx_inc = 1'b1;
                end
            end

            // The read data holds the entry just behind the scan index; it
            // moves down one slot while the one after it is fetched.
            S_SHIFT:
            begin
                if (sts.last)
                begin
                    cmd.drop   = 1'b1;
                    state_next = S_RESP;
                end
                else
                begin
                    cmd.shift_wr = 1'b1;
                    cmd.rd_en    = 1'b1;
                    cmd.rd_sel   = RD_SKIP;
                    cmd.idx_inc  = 1'b1;
                end
            end

            S_RESP:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/core/fifo_queue_with_search_delete.sv
// Top level of the FIFO queue with find and delete.
// Depends on fqsd_pkg, fqsd_ctrl and fqsd_dp.
//
// Commands enter on the input channel (in_valid, in_stall, action, value) and
// each one returns exactly one result beat on the output channel (out_valid,
// out_stall, status, position, length). A beat moves at a rising edge where
// valid is high and stall is low.
//
// One command is handled at a time. Enqueue, dequeue, clear and unused codes
// go from decode straight to the response state. Find reads entries from the
// head one by one until a match or the last entry. Delete then moves each
// entry behind the match down a slot and releases the tail slot. The entry
// memory has one registered read and one write a cycle.
//
// Entries live in a circular memory addressed from a head pointer, so dequeue
// does not move data. Reset empties the queue at once but does not clear
// the memory. While the receiver stalls, the result register holds its beat;
// the next command is still accepted and runs until its own result is ready.
module fifo_queue_with_search_delete
    import fqsd_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [ACT_W-1:0]         action,
    input  logic signed [DATA_W-1:0] value,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [STAT_W-1:0]        status,
    output logic [POS_W-1:0]         position,
    output logic [LEN_W-1:0]         length
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    fqsd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .sts      (sts)
    );

    fqsd_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .action    (action),
        .value     (value),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .status    (status),
        .position  (position),
        .length    (length),
        .cmd       (cmd),
        .sts       (sts)
    );

    // A new result never overwrites one the receiver has not taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> sts.out_free)
        else $error("result register loaded while its beat is still held");

    // After a command beat the block stays busy until the command completes.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second command accepted right behind the first");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.enq |-> !sts.full)
        else $error("enqueue written into a full queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.deq || cmd.drop) |-> !sts.empty)
        else $error("entry removed from an empty queue");

endmodule
